// ===== hdl/tvnf_pkg.sv =====
// Shared types and constants of the turbulence value noise force block.
package tvnf_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int MAX_OCT_DEF    = 8;
    localparam int TIME_FREQ_DEF  = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 3'd7;

    typedef enum logic [1:0] {
        CMD_LOAD_PERM  = 2'd0,
        CMD_LOAD_NOISE = 2'd1,
        CMD_COMPUTE    = 2'd2,
        CMD_TICK       = 2'd3
    } t_cmd;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        OP_PERM  = 2'd0,
        OP_NOISE = 2'd1,
        OP_FORCE = 2'd2
    } t_op;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] time_step;
        logic [7:0]         entry_index;
        logic [7:0]         perm_value;
        logic signed [15:0] lut_x;
        logic signed [15:0] lut_y;
        logic signed [15:0] lut_z;
        logic signed [15:0] lut_w;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] amp_x;
        logic signed [15:0] amp_y;
        logic signed [15:0] amp_z;
        logic [15:0]        freq_x;
        logic [15:0]        freq_y;
        logic [15:0]        freq_z;
        logic [15:0]        octave_ratio;
        logic [3:0]         octave_count;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [7:0]         index;
        logic [7:0]         perm;
        logic signed [15:0] lut_x;
        logic signed [15:0] lut_y;
        logic signed [15:0] lut_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tim;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hdl/turbulence_value_noise_force_core.sv =====
// Compute: the octave sequence is set by the shared multiplier, the bit-serial reciprocal
// and the one-read-per-cycle tables, walking 16 corners and 15 lerps per octave.
// Table loads are written by the back end as it takes them; ticks are absorbed by the front at once.
// Throughput is one compute at a time; the 2-entry queue and output register decouple sides.
// Reset (synchronous, active low) clears time, queue and output; tables are undefined until loaded.
module turbulence_value_noise_force_core #(
    parameter int TABLE_SIZE = tvnf_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCT    = tvnf_pkg::MAX_OCT_DEF,
    parameter int TIME_FREQ  = tvnf_pkg::TIME_FREQ_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  tvnf_pkg::t_in_item                i_item,
    output logic                              empty,
    input  logic                              pop,
    output tvnf_pkg::t_out_item               o_result,
    input  logic                              i_cfg_we,
    input  logic [tvnf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tvnf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tvnf_pkg::t_cfg   r_cfg;
    tvnf_pkg::t_job   f_job, q_job;
    tvnf_pkg::t_qstat q_stat;
    logic             q_push, q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amp_x        <= 16'sd256;
            r_cfg.amp_y        <= 16'sd256;
            r_cfg.amp_z        <= 16'sd256;
            r_cfg.freq_x       <= 16'd256;
            r_cfg.freq_y       <= 16'd256;
            r_cfg.freq_z       <= 16'd256;
            r_cfg.octave_ratio <= 16'd32768;
            r_cfg.octave_count <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tvnf_pkg::CFG_AMP_X:   r_cfg.amp_x        <= $signed(i_cfg_data);
                tvnf_pkg::CFG_AMP_Y:   r_cfg.amp_y        <= $signed(i_cfg_data);
                tvnf_pkg::CFG_AMP_Z:   r_cfg.amp_z        <= $signed(i_cfg_data);
                tvnf_pkg::CFG_FREQ_X:  r_cfg.freq_x       <= i_cfg_data;
                tvnf_pkg::CFG_FREQ_Y:  r_cfg.freq_y       <= i_cfg_data;
                tvnf_pkg::CFG_FREQ_Z:  r_cfg.freq_z       <= i_cfg_data;
                tvnf_pkg::CFG_RATIO:   r_cfg.octave_ratio <= i_cfg_data;
                tvnf_pkg::CFG_OCTAVES: r_cfg.octave_count <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    tvnf_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_qstat (q_stat),
        .o_qpush (q_push),
        .o_job   (f_job)
    );

    tvnf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_qstat (q_stat)
    );

    tvnf_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_OCT    (MAX_OCT),
        .TIME_FREQ  (TIME_FREQ)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_job    (q_job),
        .i_qstat  (q_stat),
        .o_qpop   (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // after reset the queue is not full and no result waits
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue or result not cleared by reset");
    // the queue only fills after an accepted item
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("queue became full without an item");
    // the front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("job written into full queue");
    // the back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("job taken from empty queue");
`endif

endmodule

// ===== hdl/tvnf_front.sv =====
// Front end: accepts items, keeps the time accumulator, queues table loads and computes.
module tvnf_front #(
    parameter int TABLE_SIZE = tvnf_pkg::TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tvnf_pkg::t_in_item i_item,
    output logic               o_full,
    input  tvnf_pkg::t_qstat   i_qstat,
    output logic               o_qpush,
    output tvnf_pkg::t_job     o_job
);

    logic [31:0] r_time;
    logic        accept;
    logic        in_range;

    assign o_full   = i_qstat.full;
    assign accept   = i_push && !i_qstat.full;
    assign in_range = 32'(i_item.entry_index) < TABLE_SIZE;

    // classify: loads beyond the table are dropped, ticks stay here
    always_comb begin
        o_qpush = 1'b0;
        o_job.op = tvnf_pkg::OP_FORCE;
        case (i_item.cmd)
            tvnf_pkg::CMD_LOAD_PERM: begin
                o_qpush  = accept && in_range;
                o_job.op = tvnf_pkg::OP_PERM;
            end
            tvnf_pkg::CMD_LOAD_NOISE: begin
                o_qpush  = accept && in_range;
                o_job.op = tvnf_pkg::OP_NOISE;
            end
            tvnf_pkg::CMD_COMPUTE: begin
                o_qpush  = accept;
                o_job.op = tvnf_pkg::OP_FORCE;
            end
            default: begin
                o_qpush = 1'b0;
            end
        endcase
        o_job.index = i_item.entry_index;
        o_job.perm  = i_item.perm_value;
        o_job.lut_x = i_item.lut_x;
        o_job.lut_y = i_item.lut_y;
        o_job.lut_z = i_item.lut_z;
        o_job.pos_x = i_item.pos_x;
        o_job.pos_y = i_item.pos_y;
        o_job.pos_z = i_item.pos_z;
        o_job.tim   = $signed(r_time);
    end

    // time accumulator, wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (accept && i_item.cmd == tvnf_pkg::CMD_TICK) begin
            r_time <= r_time + i_item.time_step;
        end
    end

endmodule

// ===== hdl/tvnf_fifo.sv =====
// Two-entry job queue between front and back.
module tvnf_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tvnf_pkg::t_job   i_job,
    input  logic             i_pop,
    output tvnf_pkg::t_job   o_job,
    output tvnf_pkg::t_qstat o_qstat
);

    tvnf_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_job         = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== hdl/tvnf_back.sv =====
// Back end: table memories and the octave sequencer that computes the force.
module tvnf_back #(
    parameter int TABLE_SIZE = tvnf_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCT    = tvnf_pkg::MAX_OCT_DEF,
    parameter int TIME_FREQ  = tvnf_pkg::TIME_FREQ_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tvnf_pkg::t_cfg      i_cfg,
    input  tvnf_pkg::t_job      i_job,
    input  tvnf_pkg::t_qstat    i_qstat,
    output logic                o_qpop,
    output logic                o_empty,
    input  logic                i_pop,
    output tvnf_pkg::t_out_item o_result
);

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int OCT_W = $clog2(MAX_OCT + 1);
    localparam int ACC_W = 48 + OCT_W;
    localparam int TOT_W = 32 + OCT_W;
    localparam int MA_W  = (ACC_W - 15 > 34) ? ACC_W - 15 : 34;
    localparam int MB_W  = 34;
    localparam int P_W   = MA_W + MB_W;
    localparam int R_W   = P_W - 24;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DIV    = 11'b000_0000_0010,
        S_INIT   = 11'b000_0000_0100,
        S_PERM   = 11'b000_0000_1000,
        S_CORNER = 11'b000_0001_0000,
        S_LERP   = 11'b000_0010_0000,
        S_ACC    = 11'b000_0100_0000,
        S_SCALE  = 11'b000_1000_0000,
        S_WGT    = 11'b001_0000_0000,
        S_FIN    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    // table memories
    logic [7:0]  r_perm  [TABLE_SIZE];
    logic [47:0] r_noise [TABLE_SIZE];
    logic [7:0]  r_prd;
    logic [47:0] r_nrd;
    logic [IW-1:0] wr_addr, perm_addr, noise_addr;

    // sequencer state
    tvnf_pkg::t_job     r_job;
    logic [5:0]         r_dk;
    logic [15:0]        r_rem;
    logic [32:0]        r_quo;
    logic [32:0]        r_inv;
    logic [1:0]         r_k;
    logic [1:0]         r_sub;
    logic [1:0]         r_ph;
    logic [2:0]         r_lvl;
    logic [3:0]         r_cn;
    logic [OCT_W-1:0]   r_oct;
    logic [OCT_W-1:0]   r_n;
    logic [63:0]        r_c [4];
    logic [63:0]        r_tmp;
    logic [7:0]         r_i, r_j;
    logic signed [15:0] r_carry [3];
    logic signed [15:0] r_pend [4][3];
    logic signed [33:0] r_lp [3];
    logic [31:0]        r_w;
    logic [TOT_W-1:0]   r_total;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [MA_W-1:0]  r_q;
    logic signed [P_W-1:0]   r_prod;
    logic signed [31:0]      r_res [3];
    logic                    r_ovalid;
    tvnf_pkg::t_out_item     r_out;

    logic take;
    logic [OCT_W-1:0] n_cnt;
    logic [IW-1:0] lo [4];
    logic [IW-1:0] hi [4];
    logic [15:0]   tf [4];
    logic [7:0]    px;
    logic [IW-1:0] py, pz, pw;
    logic [1:0]    lvl2;
    logic [63:0]   cc;
    logic signed [MA_W-1:0] ma;
    logic signed [MB_W-1:0] mb;
    logic [16:0]   rem_sh;
    logic          ge;
    logic [16:0]   rem_nx;
    logic [32:0]   quo_nx;
    logic signed [ACC_W-32:0] acc_hi;
    logic signed [15:0] amp_k;
    logic signed [R_W-1:0] rs;
    logic signed [31:0] sat;
    logic signed [17:0] lsum [3];

    assign take     = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_qpop   = take;
    assign o_empty  = !r_ovalid;
    assign o_result = r_out;
    assign wr_addr  = IW'(i_job.index);

    // octave count saturates at the build limit
    assign n_cnt = (32'(i_cfg.octave_count) > MAX_OCT) ? OCT_W'(MAX_OCT)
                                                       : OCT_W'(i_cfg.octave_count);

    // cell, next cell and fraction per axis
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lo[k] = r_c[k][24 +: IW];
            hi[k] = lo[k] + IW'(1);
            tf[k] = r_c[k][23:8];
        end
    end

    // corner hashing addresses
    assign px   = r_cn[0] ? r_j : r_i;
    assign py   = r_cn[1] ? hi[1] : lo[1];
    assign pz   = r_cn[2] ? hi[2] : lo[2];
    assign pw   = r_cn[3] ? hi[3] : lo[3];
    assign perm_addr  = (r_state == S_PERM) ? ((r_k == 2'd0) ? lo[0] : hi[0])
                                            : IW'(px) + py;
    assign noise_addr = IW'(r_prd) + pz + pw;

    // permutation memory
    always_ff @(posedge i_clk) begin
        if (take && i_job.op == tvnf_pkg::OP_PERM) begin
            r_perm[wr_addr] <= i_job.perm;
        end
        r_prd <= r_perm[perm_addr];
    end

    // noise vector memory
    always_ff @(posedge i_clk) begin
        if (take && i_job.op == tvnf_pkg::OP_NOISE) begin
            r_noise[wr_addr] <= {i_job.lut_x, i_job.lut_y, i_job.lut_z};
        end
        r_nrd <= r_noise[noise_addr];
    end

    // reciprocal step: one quotient bit per cycle
    assign rem_sh = {r_rem, (r_dk == 6'd32)};
    assign ge     = rem_sh >= {1'b0, i_cfg.octave_ratio};
    assign rem_nx = ge ? rem_sh - {1'b0, i_cfg.octave_ratio} : rem_sh;
    assign quo_nx = {r_quo[31:0], ge};

    // lerp lanes, one per axis
    assign lvl2 = r_lvl[1:0];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lsum[k] = 18'(r_pend[lvl2][k]) + r_lp[k][33:16];
        end
    end

    // shared multiplier operand select
    assign cc     = r_c[r_k];
    assign acc_hi = r_acc[(r_k == 2'd3) ? 2'd2 : r_k][ACC_W-1:31];
    always_comb begin
        case (r_k)
            2'd0:    amp_k = i_cfg.amp_x;
            2'd1:    amp_k = i_cfg.amp_y;
            default: amp_k = i_cfg.amp_z;
        endcase
    end

    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_INIT: begin
                case (r_k)
                    2'd0: begin
                        ma = MA_W'(r_job.pos_x);
                        mb = MB_W'(i_cfg.freq_x);
                    end
                    2'd1: begin
                        ma = MA_W'(r_job.pos_y);
                        mb = MB_W'(i_cfg.freq_y);
                    end
                    2'd2: begin
                        ma = MA_W'(r_job.pos_z);
                        mb = MB_W'(i_cfg.freq_z);
                    end
                    default: begin
                        ma = MA_W'(r_job.tim);
                        mb = MB_W'(TIME_FREQ);
                    end
                endcase
            end
            S_ACC: begin
                ma = MA_W'(r_carry[(r_k == 2'd3) ? 2'd2 : r_k]);
                mb = MB_W'(r_w);
            end
            S_SCALE: begin
                case (r_sub)
                    2'd0:    ma = MA_W'(cc[47:16]);
                    2'd1:    ma = MA_W'($signed(cc[63:48]));
                    default: ma = MA_W'(cc[15:0]);
                endcase
                mb = MB_W'(r_inv);
            end
            S_WGT: begin
                ma = MA_W'(r_w);
                mb = MB_W'(i_cfg.octave_ratio);
            end
            S_FIN: begin
                if (r_sub == 2'd0) begin
                    ma = MA_W'(acc_hi);
                    mb = MB_W'(amp_k);
                end else begin
                    ma = r_q;
                    mb = MB_W'(r_total[TOT_W-1:16]);
                end
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // saturation of the scaled result
    assign rs  = r_prod[P_W-1:24];
    always_comb begin
        if (rs > $signed(R_W'(32'h7fff_ffff))) begin
            sat = 32'sh7fff_ffff;
        end else if (rs < $signed(~R_W'(32'h7fff_ffff))) begin
            sat = -32'sh7fff_ffff - 32'sd1;
        end else begin
            sat = rs[31:0];
        end
    end

    // products are registered every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(ma) * P_W'(mb);
        for (int k = 0; k < 3; k++) begin
            r_lp[k] <= (17'(r_carry[k]) - 17'(r_pend[lvl2][k])) * $signed({1'b0, tf[lvl2]});
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ph     <= '0;
            r_k      <= '0;
            r_sub    <= '0;
            r_lvl    <= '0;
            r_cn     <= '0;
            r_dk     <= '0;
            r_oct    <= '0;
        end else begin
            if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take && i_job.op == tvnf_pkg::OP_FORCE) begin
                        r_job <= i_job;
                        r_n   <= n_cnt;
                        if (n_cnt == '0) begin
                            for (int k = 0; k < 3; k++) r_res[k] <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_dk    <= 6'd32;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= rem_nx[15:0];
                    r_quo <= quo_nx;
                    if (r_dk == '0) begin
                        r_inv   <= (i_cfg.octave_ratio == '0) ? 33'h1_0000_0000 : quo_nx;
                        r_k     <= '0;
                        r_ph    <= '0;
                        r_state <= S_INIT;
                    end else begin
                        r_dk <= r_dk - 6'd1;
                    end
                end
                S_INIT: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph     <= 2'd0;
                        r_c[r_k] <= r_prod[63:0];
                        r_k      <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            for (int k = 0; k < 3; k++) r_acc[k] <= '0;
                            r_total <= '0;
                            r_w     <= 32'h8000_0000;
                            r_oct   <= '0;
                            r_state <= S_PERM;
                        end
                    end
                end
                S_PERM: begin
                    case (r_k)
                        2'd0: r_k <= 2'd1;
                        2'd1: begin
                            r_i <= r_prd;
                            r_k <= 2'd2;
                        end
                        default: begin
                            r_j     <= r_prd;
                            r_cn    <= '0;
                            r_ph    <= '0;
                            r_state <= S_CORNER;
                        end
                    endcase
                end
                S_CORNER: begin
                    if (r_ph == 2'd2) begin
                        r_carry[0] <= $signed(r_nrd[47:32]);
                        r_carry[1] <= $signed(r_nrd[31:16]);
                        r_carry[2] <= $signed(r_nrd[15:0]);
                        r_lvl      <= '0;
                        r_ph       <= '0;
                        r_state    <= S_LERP;
                    end else begin
                        r_ph <= r_ph + 2'd1;
                    end
                end
                S_LERP: begin
                    if (r_lvl[2]) begin
                        // all 16 corners blended
                        r_k     <= '0;
                        r_ph    <= '0;
                        r_state <= S_ACC;
                    end else if (!r_cn[lvl2]) begin
                        for (int k = 0; k < 3; k++) r_pend[lvl2][k] <= r_carry[k];
                        r_cn    <= r_cn + 4'd1;
                        r_ph    <= '0;
                        r_state <= S_CORNER;
                    end else if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        for (int k = 0; k < 3; k++) r_carry[k] <= lsum[k][15:0];
                        r_lvl <= r_lvl + 3'd1;
                        r_ph  <= 2'd0;
                    end
                end
                S_ACC: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph     <= 2'd0;
                        r_acc[r_k] <= r_acc[r_k] + $signed(r_prod[ACC_W-1:0]);
                        if (r_k == 2'd2) begin
                            r_total <= r_total + TOT_W'(r_w);
                            r_k     <= '0;
                            r_sub   <= '0;
                            r_state <= S_SCALE;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                S_SCALE: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        case (r_sub)
                            2'd0: begin
                                r_tmp <= r_prod[63:0];
                                r_sub <= 2'd1;
                            end
                            2'd1: begin
                                r_tmp <= r_tmp + {r_prod[31:0], 32'd0};
                                r_sub <= 2'd2;
                            end
                            default: begin
                                r_c[r_k] <= r_tmp + 64'(r_prod[48:16]);
                                r_sub    <= 2'd0;
                                r_k      <= r_k + 2'd1;
                                if (r_k == 2'd3) begin
                                    r_state <= S_WGT;
                                end
                            end
                        endcase
                    end
                end
                S_WGT: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        r_w  <= r_prod[47:16];
                        r_k  <= '0;
                        if (r_oct == r_n - OCT_W'(1)) begin
                            r_sub   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_oct   <= r_oct + OCT_W'(1);
                            r_state <= S_PERM;
                        end
                    end
                end
                S_FIN: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (r_sub == 2'd0) begin
                            r_q   <= r_prod[MA_W-1:0];
                            r_sub <= 2'd1;
                        end else begin
                            r_res[r_k] <= sat;
                            r_sub      <= 2'd0;
                            r_k        <= r_k + 2'd1;
                            if (r_k == 2'd2) begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid      <= 1'b1;
                        r_out.force_x <= r_res[0];
                        r_out.force_y <= r_res[1];
                        r_out.force_z <= r_res[2];
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
